// File: rtl/tmc_pkg.sv
// Shared types and constants for the touch trimmed-mean calibration block.
// No dependencies; imported by every module of the block.
package tmc_pkg;

    // Sample and run geometry
    localparam int ADC_BITS       = 12;
    localparam int SUM_BITS       = ADC_BITS + 4;
    localparam int RUN_LEN        = 10;
    localparam int RUN_CNT_BITS   = 4;
    localparam int TRIM_SHIFT     = 3;

    // Calibration arithmetic
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 16;
    localparam int PROD_BITS      = COEF_BITS + ADC_BITS + 1;
    localparam int ACC_BITS       = PROD_BITS + 3;
    localparam int QUOT_BITS      = ACC_BITS - COEF_FRAC_BITS;

    // Screen clamp
    localparam int LIMIT_BITS     = 11;
    localparam int SCREEN_BITS    = 10;
    localparam int SCREEN_MAX     = 1024;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int WIDTH_RESET    = 240;
    localparam int HEIGHT_RESET   = 320;

    // Queue between front and back
    localparam int MID_DEPTH      = 4;
    localparam int MID_PTR_BITS   = 2;
    localparam int MID_CNT_BITS   = 3;

    // Result queue at the back
    localparam int OUT_DEPTH      = 4;
    localparam int OUT_PTR_BITS   = 2;
    localparam int OUT_CNT_BITS   = 3;
    localparam int OCC_BITS       = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GAIN_X_FROM_X = 3'd0,
        REG_GAIN_X_FROM_Y = 3'd1,
        REG_OFFSET_X      = 3'd2,
        REG_GAIN_Y_FROM_X = 3'd3,
        REG_GAIN_Y_FROM_Y = 3'd4,
        REG_OFFSET_Y      = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] gain_x_from_x;
        logic signed [COEF_BITS-1:0] gain_x_from_y;
        logic signed [COEF_BITS-1:0] offset_x;
        logic signed [COEF_BITS-1:0] gain_y_from_x;
        logic signed [COEF_BITS-1:0] gain_y_from_y;
        logic signed [COEF_BITS-1:0] offset_y;
        logic [LIMIT_BITS-1:0]       screen_width;
        logic [LIMIT_BITS-1:0]       screen_height;
    } cfg_t;

    // Trimmed mean pair handed from front to back
    typedef struct packed {
        logic [ADC_BITS-1:0] raw_x;
        logic [ADC_BITS-1:0] raw_y;
    } mid_item_t;

    // Status of the queue between front and back
    typedef struct packed {
        logic                    empty;
        logic [MID_CNT_BITS-1:0] count;
    } mid_status_t;

    typedef struct packed {
        logic [ADC_BITS-1:0]    raw_x;
        logic [ADC_BITS-1:0]    raw_y;
        logic [SCREEN_BITS-1:0] screen_x;
        logic [SCREEN_BITS-1:0] screen_y;
    } out_item_t;

endpackage

// File: rtl/tmc_front.sv
// Front end: takes sample requests, keeps the per-run sum/min/max and
// emits the trimmed mean pair into the middle queue. Depends on tmc_pkg.
module tmc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [11:0]             sample_x,
    input  logic [11:0]             sample_y,
    input  logic                    pen_down,
    input  tmc_pkg::mid_status_t    mid_status,
    output logic                    full,
    output logic                    mid_push,
    output tmc_pkg::mid_item_t      mid_item
);
    import tmc_pkg::*;

    logic [RUN_CNT_BITS-1:0] run_count_reg, run_count_next;
    logic                    done_reg, done_next;
    logic [SUM_BITS-1:0]     sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [ADC_BITS-1:0]     min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic [ADC_BITS-1:0]     min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic [ADC_BITS-1:0]     sx, sy;
    logic                    accept;
    logic [MID_CNT_BITS:0]   mid_fill;

    // (sum - min - max) >> 3; never wraps since sum has room for sixteen full-scale samples
    function automatic logic [ADC_BITS-1:0] trim_mean(
        input logic [SUM_BITS-1:0] sum,
        input logic [ADC_BITS-1:0] lo,
        input logic [ADC_BITS-1:0] hi
    );
        logic [SUM_BITS-1:0] diff;
        diff = sum - SUM_BITS'(lo) - SUM_BITS'(hi);
        return diff[ADC_BITS+TRIM_SHIFT-1:TRIM_SHIFT];
    endfunction

    // Hold off while the queue has no room for a pending pair
    assign mid_fill = (MID_CNT_BITS+1)'(mid_status.count) + (MID_CNT_BITS+1)'(done_reg);
    assign full     = (mid_fill >= (MID_CNT_BITS+1)'(MID_DEPTH));
    assign accept   = push && !full;

    assign sx = sample_x[ADC_BITS-1:0];
    assign sy = sample_y[ADC_BITS-1:0];

    // Run accumulation
    always_comb
    begin
        run_count_next = run_count_reg;
        done_next      = 1'b0;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        if (accept)
        begin
            if (!pen_down)
            begin
                run_count_next = '0;
            end
            else
            begin
                if (run_count_reg == '0)
                begin
                    sum_x_next = SUM_BITS'(sx);
                    sum_y_next = SUM_BITS'(sy);
                    min_x_next = sx;
                    max_x_next = sx;
                    min_y_next = sy;
                    max_y_next = sy;
                end
                else
                begin
                    sum_x_next = sum_x_reg + SUM_BITS'(sx);
                    sum_y_next = sum_y_reg + SUM_BITS'(sy);
                    if (sx < min_x_reg) min_x_next = sx;
                    if (sx > max_x_reg) max_x_next = sx;
                    if (sy < min_y_reg) min_y_next = sy;
                    if (sy > max_y_reg) max_y_next = sy;
                end
                if (run_count_reg == RUN_CNT_BITS'(RUN_LEN - 1))
                begin
                    run_count_next = '0;
                    done_next      = 1'b1;
                end
                else
                begin
                    run_count_next = run_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            run_count_reg <= run_count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_x_reg <= sum_x_next;
        sum_y_reg <= sum_y_next;
        min_x_reg <= min_x_next;
        max_x_reg <= max_x_next;
        min_y_reg <= min_y_next;
        max_y_reg <= max_y_next;
    end

    // Finished run: registers hold the final totals while done_reg is high
    assign mid_push       = done_reg;
    assign mid_item.raw_x = trim_mean(sum_x_reg, min_x_reg, max_x_reg);
    assign mid_item.raw_y = trim_mean(sum_y_reg, min_y_reg, max_y_reg);

    a_run_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_count_reg < RUN_CNT_BITS'(RUN_LEN))
        else $error("run count out of range");

    a_push_after_pen: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> $past(accept && pen_down))
        else $error("trimmed pair without a pen-down request");

endmodule

// File: rtl/tmc_mid_queue.sv
// Short queue of trimmed mean pairs between the front and the back.
// Depends on tmc_pkg.
module tmc_mid_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  tmc_pkg::mid_item_t    wr_item,
    input  logic                  rd_en,
    output tmc_pkg::mid_item_t    rd_item,
    output tmc_pkg::mid_status_t  status
);
    import tmc_pkg::*;

    mid_item_t               mem [MID_DEPTH];
    logic [MID_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [MID_CNT_BITS-1:0] count_reg;
    logic                    do_rd;

    assign do_rd        = rd_en && (count_reg != '0);
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;
    assign rd_item      = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (!wr_en && do_rd)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == MID_CNT_BITS'(MID_DEPTH)) |-> !wr_en)
        else $error("middle queue written while full");

endmodule

// File: rtl/tmc_back.sv
// Back end: affine calibration pipeline (multiply, sum, clamp) and the
// result queue seen on the output side. Depends on tmc_pkg.
module tmc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmc_pkg::cfg_t          cfg,
    input  tmc_pkg::mid_status_t   mid_status,
    input  tmc_pkg::mid_item_t     mid_item,
    output logic                   mid_pop,
    input  logic                   pop,
    output logic                   empty,
    output tmc_pkg::out_item_t     result
);
    import tmc_pkg::*;

    logic                        s1_valid_reg, s2_valid_reg;
    mid_item_t                   s1_raw_reg, s2_raw_reg;
    logic signed [PROD_BITS-1:0] p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg;
    logic signed [ACC_BITS-1:0]  acc_x_reg, acc_y_reg;
    logic signed [ACC_BITS-1:0]  acc_x_next, acc_y_next;
    logic signed [ADC_BITS:0]    rx_s, ry_s;

    out_item_t                   out_mem [OUT_DEPTH];
    out_item_t                   wr_item;
    logic [OUT_PTR_BITS-1:0]     out_wr_ptr_reg, out_rd_ptr_reg;
    logic [OUT_CNT_BITS-1:0]     out_count_reg;
    logic [OCC_BITS-1:0]         occupancy;
    logic                        do_rd;

    // Negative sums clamp to zero, so floor and truncation agree here
    function automatic logic [SCREEN_BITS-1:0] clamp_axis(
        input logic signed [ACC_BITS-1:0] acc,
        input logic [LIMIT_BITS-1:0]      limit
    );
        logic [LIMIT_BITS-1:0] lim;
        logic [LIMIT_BITS-1:0] lim_m1;
        logic [QUOT_BITS-1:0]  q;
        if (limit == '0)
            lim = LIMIT_BITS'(1);
        else if (limit > LIMIT_BITS'(SCREEN_MAX))
            lim = LIMIT_BITS'(SCREEN_MAX);
        else
            lim = limit;
        lim_m1 = lim - 1'b1;
        q      = acc[ACC_BITS-1:COEF_FRAC_BITS];
        if (acc[ACC_BITS-1])
            return '0;
        else if (q >= QUOT_BITS'(lim))
            return lim_m1[SCREEN_BITS-1:0];
        else
            return q[SCREEN_BITS-1:0];
    endfunction

    // Take a pair only if the result queue can absorb everything in flight
    assign occupancy = OCC_BITS'(out_count_reg) + OCC_BITS'(s1_valid_reg)
                     + OCC_BITS'(s2_valid_reg);
    assign mid_pop   = !mid_status.empty && (occupancy < OCC_BITS'(OUT_DEPTH));

    assign rx_s = $signed({1'b0, mid_item.raw_x});
    assign ry_s = $signed({1'b0, mid_item.raw_y});

    // Stage 1: four coefficient products
    always_ff @(posedge clk)
    begin
        s1_raw_reg <= mid_item;
        p_xx_reg   <= PROD_BITS'(cfg.gain_x_from_x) * PROD_BITS'(rx_s);
        p_xy_reg   <= PROD_BITS'(cfg.gain_x_from_y) * PROD_BITS'(ry_s);
        p_yx_reg   <= PROD_BITS'(cfg.gain_y_from_x) * PROD_BITS'(rx_s);
        p_yy_reg   <= PROD_BITS'(cfg.gain_y_from_y) * PROD_BITS'(ry_s);
    end

    // Stage 2: affine sums
    assign acc_x_next = ACC_BITS'(p_xx_reg) + ACC_BITS'(p_xy_reg) + ACC_BITS'(cfg.offset_x);
    assign acc_y_next = ACC_BITS'(p_yx_reg) + ACC_BITS'(p_yy_reg) + ACC_BITS'(cfg.offset_y);

    always_ff @(posedge clk)
    begin
        s2_raw_reg <= s1_raw_reg;
        acc_x_reg  <= acc_x_next;
        acc_y_reg  <= acc_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= mid_pop;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Clamp and write into the result queue
    assign wr_item.raw_x    = s2_raw_reg.raw_x;
    assign wr_item.raw_y    = s2_raw_reg.raw_y;
    assign wr_item.screen_x = clamp_axis(acc_x_reg, cfg.screen_width);
    assign wr_item.screen_y = clamp_axis(acc_y_reg, cfg.screen_height);

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            out_mem[out_wr_ptr_reg] <= wr_item;
    end

    assign do_rd  = pop && (out_count_reg != '0);
    assign empty  = (out_count_reg == '0);
    assign result = out_mem[out_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (s2_valid_reg)
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            if (do_rd)
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            if (s2_valid_reg && !do_rd)
                out_count_reg <= out_count_reg + 1'b1;
            else if (!s2_valid_reg && do_rd)
                out_count_reg <= out_count_reg - 1'b1;
        end
    end

    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= OCC_BITS'(OUT_DEPTH))
        else $error("result queue overcommitted");

    a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("stage 2 valid without stage 1");

endmodule

// File: rtl/touch_trimmed_mean_calibrate.sv
// Touch sample smoother with affine calibration, top level: configuration
// registers and the front / middle queue / back hookup. Depends on tmc_pkg,
// tmc_front, tmc_mid_queue and tmc_back.
//
// One sample request is taken per clock while full is low. While pen_down
// stays high, ten samples form a run; the tenth yields one result with the
// trimmed means ((sum - min - max) >> 3) and the clamped display coordinate.
// A pen-up request drops the run and yields nothing. A result passes from
// the front's done register through the middle queue, the two-stage
// multiply/sum pipeline and the result queue to the output side. full rises
// only when the finished runs in the four-entry middle queue, counting a
// pending one from the front, reach four, which happens only if pop is held
// off long enough for the back's four-entry result queue to fill. Coefficients
// and screen limits must be written while no request is in progress.
module touch_trimmed_mean_calibrate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [11:0] sample_x,
    input  logic [11:0] sample_y,
    input  logic        pen_down,
    input  logic        pop,
    output logic        empty,
    output logic [11:0] raw_x,
    output logic [11:0] raw_y,
    output logic [9:0]  screen_x,
    output logic [9:0]  screen_y
);
    import tmc_pkg::*;

    cfg_t        cfg_reg;
    mid_status_t mid_status;
    mid_item_t   front_item, queue_item;
    logic        mid_push, mid_pop;
    out_item_t   result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_x_from_x <= '0;
            cfg_reg.gain_x_from_y <= '0;
            cfg_reg.offset_x      <= '0;
            cfg_reg.gain_y_from_x <= '0;
            cfg_reg.gain_y_from_y <= '0;
            cfg_reg.offset_y      <= '0;
            cfg_reg.screen_width  <= LIMIT_BITS'(WIDTH_RESET);
            cfg_reg.screen_height <= LIMIT_BITS'(HEIGHT_RESET);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_GAIN_X_FROM_X: cfg_reg.gain_x_from_x <= $signed(cfg_data);
                REG_GAIN_X_FROM_Y: cfg_reg.gain_x_from_y <= $signed(cfg_data);
                REG_OFFSET_X:      cfg_reg.offset_x      <= $signed(cfg_data);
                REG_GAIN_Y_FROM_X: cfg_reg.gain_y_from_x <= $signed(cfg_data);
                REG_GAIN_Y_FROM_Y: cfg_reg.gain_y_from_y <= $signed(cfg_data);
                REG_OFFSET_Y:      cfg_reg.offset_y      <= $signed(cfg_data);
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[LIMIT_BITS-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[LIMIT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    tmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .sample_x   (sample_x),
        .sample_y   (sample_y),
        .pen_down   (pen_down),
        .mid_status (mid_status),
        .full       (full),
        .mid_push   (mid_push),
        .mid_item   (front_item)
    );

    tmc_mid_queue u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_item (front_item),
        .rd_en   (mid_pop),
        .rd_item (queue_item),
        .status  (mid_status)
    );

    tmc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .mid_status (mid_status),
        .mid_item   (queue_item),
        .mid_pop    (mid_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    assign raw_x    = result.raw_x;
    assign raw_y    = result.raw_y;
    assign screen_x = result.screen_x;
    assign screen_y = result.screen_y;

endmodule

// File: sim/tb_touch_trimmed_mean_calibrate.sv
// Self-checking testbench for touch_trimmed_mean_calibrate: trimmed-mean runs and
// clamped affine mapping, checked against a predictor written here.
// Depends on tmc_pkg and the touch_trimmed_mean_calibrate RTL.
module tb_touch_trimmed_mean_calibrate;
    import tmc_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 8;

    // One row of the directed table: a sample repeated reps times
    typedef struct {
        logic [ADC_BITS-1:0] x;
        logic [ADC_BITS-1:0] y;
        logic                pen;
        int                  reps;
        bit                  typed;
        out_item_t           point;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [31:0]           cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [11:0]           sample_x = '0;
    logic [11:0]           sample_y = '0;
    logic                  pen_down = 1'b0;
    logic                  pop = 1'b0;
    logic                  empty;
    logic [11:0]           raw_x;
    logic [11:0]           raw_y;
    logic [9:0]            screen_x;
    logic [9:0]            screen_y;

    // Predictor state: calibration copy and the current run
    cfg_t                  cal;
    int                    run_len;
    logic [SUM_BITS-1:0]   sum_x, sum_y;
    logic [ADC_BITS-1:0]   min_x, max_x, min_y, max_y;

    out_item_t             pending_points[$];
    int                    errors = 0;
    int                    samples_sent = 0;
    int                    idle_pct = 7;
    int                    stall_cycles = 0;
    bit                    hold_request = 0;
    logic                  hold_results = 1'b0;

    // Reset config: all gains zero, so every run maps to the screen origin
    stim_row_t directed_rows[5] = '{
        '{12'hFFF, 12'h000, 1'b0, 1,  1'b0, '0},
        '{12'd100, 12'd3000, 1'b1, 3, 1'b0, '0},
        '{12'hFFF, 12'hFFF, 1'b0, 1,  1'b0, '0},
        '{12'hFFF, 12'h000, 1'b1, 10, 1'b1, '{12'hFFF, 12'h000, 10'd0, 10'd0}},
        '{12'h000, 12'hFFF, 1'b1, 10, 1'b1, '{12'h000, 12'hFFF, 10'd0, 10'd0}}
    };

    touch_trimmed_mean_calibrate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .pen_down     (pen_down),
        .pop          (pop),
        .empty        (empty),
        .raw_x        (raw_x),
        .raw_y        (raw_y),
        .screen_x     (screen_x),
        .screen_y     (screen_y)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Affine map of one axis, truncated toward zero and clamped to the screen
    function automatic logic [SCREEN_BITS-1:0] calibrate_axis(
        input logic signed [COEF_BITS-1:0] ga,
        input logic signed [COEF_BITS-1:0] gb,
        input logic signed [COEF_BITS-1:0] off,
        input logic [ADC_BITS-1:0]         a,
        input logic [ADC_BITS-1:0]         b,
        input logic [LIMIT_BITS-1:0]       limit
    );
        longint acc;
        longint q;
        longint lim;
        acc = longint'(ga) * longint'(a) + longint'(gb) * longint'(b) + longint'(off);
        q = acc / (longint'(1) << COEF_FRAC_BITS);
        lim = longint'(limit);
        if (lim < 1)
            lim = 1;
        if (lim > SCREEN_MAX)
            lim = SCREEN_MAX;
        if (q < 0)
            q = 0;
        if (q >= lim)
            q = lim - 1;
        return q[SCREEN_BITS-1:0];
    endfunction

    // Fold one accepted sample into the run; done is set on the tenth one
    task automatic accumulate_sample(
        input  logic [ADC_BITS-1:0] sx,
        input  logic [ADC_BITS-1:0] sy,
        input  logic                pen,
        output bit                  done,
        output out_item_t           point
    );
        logic [ADC_BITS-1:0] rx;
        logic [ADC_BITS-1:0] ry;
        logic [SUM_BITS-1:0] trimmed;
        done = 0;
        point = '0;
        if (!pen)
        begin
            run_len = 0;
            return;
        end
        if (run_len == 0)
        begin
            sum_x = SUM_BITS'(sx);
            sum_y = SUM_BITS'(sy);
            min_x = sx;
            max_x = sx;
            min_y = sy;
            max_y = sy;
        end
        else
        begin
            sum_x = sum_x + SUM_BITS'(sx);
            sum_y = sum_y + SUM_BITS'(sy);
            if (sx < min_x) min_x = sx;
            if (sx > max_x) max_x = sx;
            if (sy < min_y) min_y = sy;
            if (sy > max_y) max_y = sy;
        end
        run_len++;
        if (run_len < RUN_LEN)
            return;
        run_len = 0;
        trimmed = sum_x - SUM_BITS'(min_x) - SUM_BITS'(max_x);
        rx = ADC_BITS'(trimmed >> TRIM_SHIFT);
        trimmed = sum_y - SUM_BITS'(min_y) - SUM_BITS'(max_y);
        ry = ADC_BITS'(trimmed >> TRIM_SHIFT);
        point.raw_x = rx;
        point.raw_y = ry;
        point.screen_x = calibrate_axis(cal.gain_x_from_x, cal.gain_x_from_y, cal.offset_x,
                                        rx, ry, cal.screen_width);
        point.screen_y = calibrate_axis(cal.gain_y_from_x, cal.gain_y_from_y, cal.offset_y,
                                        rx, ry, cal.screen_height);
        done = 1;
    endtask

    // Register write; the predictor's copy follows the same write
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_GAIN_X_FROM_X: cal.gain_x_from_x = data;
            REG_GAIN_X_FROM_Y: cal.gain_x_from_y = data;
            REG_OFFSET_X:      cal.offset_x = data;
            REG_GAIN_Y_FROM_X: cal.gain_y_from_x = data;
            REG_GAIN_Y_FROM_Y: cal.gain_y_from_y = data;
            REG_OFFSET_Y:      cal.offset_y = data;
            REG_SCREEN_WIDTH:  cal.screen_width = data[LIMIT_BITS-1:0];
            REG_SCREEN_HEIGHT: cal.screen_height = data[LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(REG_GAIN_X_FROM_X, s.gain_x_from_x);
        write_reg(REG_GAIN_X_FROM_Y, s.gain_x_from_y);
        write_reg(REG_OFFSET_X, s.offset_x);
        write_reg(REG_GAIN_Y_FROM_X, s.gain_y_from_x);
        write_reg(REG_GAIN_Y_FROM_Y, s.gain_y_from_y);
        write_reg(REG_OFFSET_Y, s.offset_y);
        write_reg(REG_SCREEN_WIDTH, CFG_DATA_BITS'(s.screen_width));
        write_reg(REG_SCREEN_HEIGHT, CFG_DATA_BITS'(s.screen_height));
        cfg_write_en <= 1'b0;
    endtask

    // Offer one sample request and wait for it to be taken
    task automatic offer_sample(
        input logic [ADC_BITS-1:0] x,
        input logic [ADC_BITS-1:0] y,
        input logic                pen,
        input bit                  typed = 0,
        input out_item_t           typed_point = '0
    );
        bit        done;
        out_item_t point;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        sample_x <= x;
        sample_y <= y;
        pen_down <= pen;
        do
            @(posedge clk);
        while (full);
        accumulate_sample(x, y, pen, done, point);
        if (pen)
            samples_sent++;
        if (done)
            pending_points.push_back(typed ? typed_point : point);
    endtask

    function automatic logic [ADC_BITS-1:0] clip_sample(input int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return 12'hFFF;
        return ADC_BITS'(v);
    endfunction

    // One run of ten pen-down samples; with breaks on, it may end early on a pen-up
    task automatic send_run(input bit allow_breaks);
        int                  mode;
        int                  cx;
        int                  cy;
        int                  spread;
        int                  stop_at;
        logic [ADC_BITS-1:0] x;
        logic [ADC_BITS-1:0] y;
        mode = $urandom_range(0, 3);
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        spread = (mode == 1) ? 63 : 600;
        stop_at = (allow_breaks && $urandom_range(0, 7) == 0) ? $urandom_range(0, 9) : RUN_LEN;
        for (int i = 0; i < RUN_LEN; i++)
        begin
            if (i == stop_at)
            begin
                offer_sample(ADC_BITS'($urandom), ADC_BITS'($urandom), 1'b0);
                break;
            end
            case (mode)
                0:
                begin
                    x = ADC_BITS'($urandom);
                    y = ADC_BITS'($urandom);
                end
                2:
                begin
                    x = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    y = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                end
                default:
                begin
                    x = clip_sample(cx + int'($urandom_range(0, 2 * spread)) - spread);
                    y = clip_sample(cy + int'($urandom_range(0, 2 * spread)) - spread);
                end
            endcase
            offer_sample(x, y, 1'b1);
        end
    endtask

    // Stop sending, wait for every expected point, then let the pipeline settle
    task automatic finish_phase();
        push <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            errors++;
        end
    endfunction

    // Result side: check each popped point, then pick the next pop level
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point, actual raw %0d/%0d screen %0d/%0d",
                         $time, raw_x, raw_y, screen_x, screen_y);
                errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                check_field("raw_x", want.raw_x, raw_x);
                check_field("raw_y", want.raw_y, raw_y);
                check_field("screen_x", want.screen_x, screen_x);
                check_field("screen_y", want.screen_y, screen_y);
            end
        end
        pop <= !hold_results && ($urandom_range(0, 99) >= idle_pct);
    end

    // Long hold-off on the result side, so the block backs up and raises full
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // Watchdog on cycles with no request accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        cfg_t s;
        int   target;
        cal = '0;
        cal.screen_width = LIMIT_BITS'(WIDTH_RESET);
        cal.screen_height = LIMIT_BITS'(HEIGHT_RESET);
        run_len = 0;
        sum_x = '0;
        sum_y = '0;
        min_x = '0;
        max_x = '0;
        min_y = '0;
        max_y = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset settings
        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                offer_sample(directed_rows[r].x, directed_rows[r].y, directed_rows[r].pen,
                             directed_rows[r].typed, directed_rows[r].point);
        finish_phase();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            s = '0;
            case (p)
                0:
                begin
                    // plain scaling onto a 240 x 320 panel
                    s.gain_x_from_x = 32'sd3840;
                    s.gain_y_from_y = 32'sd5120;
                    s.screen_width = 11'd240;
                    s.screen_height = 11'd320;
                end
                1:
                begin
                    // rotated and mirrored, widest screen and one-pixel height
                    s.gain_x_from_y = -32'sd5120;
                    s.offset_x = 32'sd20971520;
                    s.gain_y_from_x = -32'sd3840;
                    s.offset_y = 32'sd15728640;
                    s.screen_width = 11'd1024;
                    s.screen_height = 11'd1;
                end
                2:
                begin
                    // coefficient extremes, zero width and oversized height
                    s.gain_x_from_x = 32'h7FFFFFFF;
                    s.gain_x_from_y = 32'h80000000;
                    s.offset_x = 32'h7FFFFFFF;
                    s.gain_y_from_x = 32'h80000000;
                    s.gain_y_from_y = 32'h7FFFFFFF;
                    s.offset_y = 32'h80000000;
                    s.screen_width = 11'd0;
                    s.screen_height = 11'h7FF;
                end
                default:
                begin
                    // mostly usable gains, sometimes full-range words
                    s.gain_x_from_x = $urandom_range(0, 3) == 0 ? $urandom
                                      : int'($urandom_range(0, 262143)) - 131072;
                    s.gain_x_from_y = $urandom_range(0, 3) == 0 ? $urandom
                                      : int'($urandom_range(0, 262143)) - 131072;
                    s.offset_x = $urandom_range(0, 3) == 0 ? $urandom
                                 : int'($urandom_range(0, 134217727)) - 33554432;
                    s.gain_y_from_x = $urandom_range(0, 3) == 0 ? $urandom
                                      : int'($urandom_range(0, 262143)) - 131072;
                    s.gain_y_from_y = $urandom_range(0, 3) == 0 ? $urandom
                                      : int'($urandom_range(0, 262143)) - 131072;
                    s.offset_y = $urandom_range(0, 3) == 0 ? $urandom
                                 : int'($urandom_range(0, 134217727)) - 33554432;
                    s.screen_width = LIMIT_BITS'($urandom_range(0, 1100));
                    s.screen_height = $urandom_range(0, 7) == 0 ? LIMIT_BITS'($urandom)
                                      : LIMIT_BITS'($urandom_range(0, 1100));
                end
            endcase
            apply_settings(s);
            idle_pct = (p < 2) ? 0 : 7;
            if (p == 0)
                hold_request = 1;
            target = samples_sent + ((p == 0) ? 200 : 95);
            while (samples_sent < target)
                send_run(p != 0);
            finish_phase();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: touch_trimmed_mean_calibrate.f
rtl/tmc_pkg.sv
rtl/tmc_front.sv
rtl/tmc_mid_queue.sv
rtl/tmc_back.sv
rtl/touch_trimmed_mean_calibrate.sv
sim/tb_touch_trimmed_mean_calibrate.sv
